// ----- rtl/core/nnfq_pkg.sv -----
// Shared types, constants and the note frequency table of the note quantiser.
package nnfq_pkg;

  // Field widths and table geometry.
  localparam int FREQ_W       = 24;
  localparam int OUT_W        = 22;
  localparam int NOTE_COUNT   = 128;
  localparam int FRAC_BITS    = 8;
  localparam int CNT_W        = $clog2(NOTE_COUNT + 1);
  localparam int ADDR_W       = $clog2(NOTE_COUNT);
  localparam int SEARCH_STEPS = CNT_W;

  localparam logic [OUT_W-1:0]  OUT_MAX           = {OUT_W{1'b1}};
  localparam logic [FREQ_W-1:0] SILENCE_FLOOR_RST = FREQ_W'(5120);

  // Semitone factors 2^(k/12), scaled by 10^11.
  localparam logic [63:0] ScaleDec = 64'd100000000000;
  localparam logic [11:0][63:0] SEMI_RATIO = {
    64'd188774862536, 64'd178179743628, 64'd168179283051, 64'd158740105197,
    64'd149830707688, 64'd141421356237, 64'd133483985417, 64'd125992104989,
    64'd118920711500, 64'd112246204831, 64'd105946309436, 64'd100000000000
  };

  typedef logic [NOTE_COUNT-1:0][OUT_W-1:0] note_tab_t;

  // One item on its way through the search.
  typedef struct packed {
    logic [FREQ_W-1:0] x;
    logic              silent;
    logic [CNT_W-1:0]  below;
  } nnfq_item_t;

  // Equal-tempered note frequency, note 69 at 440 Hz, rounded half up.
  function automatic logic [OUT_W-1:0] note_value(int idx);
    int          t;
    int          octave;
    int          semi;
    int          down;
    logic [63:0] num;
    logic [63:0] den_half;
    logic [63:0] q;
    t      = idx + 3;
    octave = t / 12 - 6;
    semi   = t % 12;
    num    = (64'd440 * SEMI_RATIO[semi]) << FRAC_BITS;
    down   = 0;
    if (octave > 0) begin
      num = num << octave;
    end else begin
      down = -octave;
    end
    den_half = (ScaleDec << down) >> 1;
    // Dividing by the decimal scale first and the power of two second is exact.
    q = ((num + den_half) / ScaleDec) >> down;
    if (q > 64'(OUT_MAX)) begin
      q = 64'(OUT_MAX);
    end
    return q[OUT_W-1:0];
  endfunction

  function automatic note_tab_t build_table();
    note_tab_t tab;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      tab[i] = note_value(i);
    end
    return tab;
  endfunction

  localparam note_tab_t NOTE_TABLE = build_table();

endpackage

// ----- rtl/core/nnfq_search.sv -----
// Pipelined binary search that counts the table entries at or below each sample.
module nnfq_search (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [nnfq_pkg::FREQ_W-1:0] floor_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [nnfq_pkg::FREQ_W-1:0] freq_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output nnfq_pkg::nnfq_item_t      item_o
);
  import nnfq_pkg::*;

  logic [SEARCH_STEPS-1:0] vld_q;
  logic [SEARCH_STEPS-1:0] rdy;
  nnfq_item_t              item_q [SEARCH_STEPS];
  nnfq_item_t              item_d [SEARCH_STEPS];
  nnfq_item_t              first;

  // The entry stage also decides whether the sample is silent.
  always_comb begin
    first.x      = freq_i;
    first.silent = freq_i < floor_i;
    first.below  = '0;
  end

  // One search step per stage, most significant count bit first.
  for (genvar s = 0; s < SEARCH_STEPS; s++) begin : g_step
    localparam int B = SEARCH_STEPS - 1 - s;
    nnfq_item_t       prev;
    logic [CNT_W-1:0] cand;
    logic [CNT_W-1:0] cand_m1;
    logic             take;

    if (s == 0) begin : g_head
      assign prev = first;
    end else begin : g_body
      assign prev = item_q[s-1];
    end

    assign cand    = prev.below | (CNT_W'(1) << B);
    assign cand_m1 = cand - CNT_W'(1);
    assign take    = (cand <= CNT_W'(NOTE_COUNT)) &&
                     (FREQ_W'(NOTE_TABLE[cand_m1[ADDR_W-1:0]]) <= prev.x);

    always_comb begin
      item_d[s]       = prev;
      item_d[s].below = take ? cand : prev.below;
    end

    // A stage takes a new item when it is empty or its item moves on.
    if (s == SEARCH_STEPS - 1) begin : g_last
      assign rdy[s] = !vld_q[s] || ready_i;
    end else begin : g_mid
      assign rdy[s] = !vld_q[s] || rdy[s+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= (s == 0) ? valid_i : vld_q[(s == 0) ? 0 : s - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        item_q[s] <= item_d[s];
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[SEARCH_STEPS-1];
  assign item_o  = item_q[SEARCH_STEPS-1];

`ifndef SYNTH
  // The count never exceeds the number of notes.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> item_o.below <= CNT_W'(NOTE_COUNT))
    else $error("search count out of range");

  // Every entry counted lies at or below the sample.
  a_lower_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (item_o.below != '0) |->
      FREQ_W'(NOTE_TABLE[ADDR_W'(item_o.below - CNT_W'(1))]) <= item_o.x)
    else $error("entry below the count exceeds the sample");

  // The first entry not counted lies above the sample.
  a_upper_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (item_o.below < CNT_W'(NOTE_COUNT)) |->
      FREQ_W'(NOTE_TABLE[ADDR_W'(item_o.below)]) > item_o.x)
    else $error("entry at the count is not above the sample");
`endif

endmodule

// ----- rtl/core/nearest_note_freq_quantizer.sv -----
// Top level of the nearest note frequency quantiser.
// Each item is a sample in unsigned Q16.8 hertz and gives one result item: the nearest
// equal-tempered note frequency (note 69 at 440 Hz) in Q14.8, an exact tie going to the
// upper note, or zero when the sample lies below the silence floor. The block takes one
// item per cycle while the output is not stalled. Each accepted item passes through,
// in order, eight stages of the binary search over the 128-entry note table
// (one table compare per stage, the first loaded at the accepting edge), one stage that
// fetches the two neighbouring notes and one output register that picks the nearer. The
// silence floor resets to 20 Hz and may only be written while no item is in flight.
module nearest_note_freq_quantizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [nnfq_pkg::FREQ_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [nnfq_pkg::FREQ_W-1:0] in_freq_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [nnfq_pkg::OUT_W-1:0]  out_freq_o
);
  import nnfq_pkg::*;

  logic [FREQ_W-1:0] floor_q;
  logic              srch_vld;
  logic              fetch_rdy;
  nnfq_item_t        srch_item;
  logic              fetch_vld_q;
  logic [FREQ_W-1:0] fetch_x_q;
  logic              fetch_silent_q;
  logic [OUT_W-1:0]  lo_v_q;
  logic [OUT_W-1:0]  hi_v_q;
  logic [ADDR_W-1:0] lo_addr;
  logic [ADDR_W-1:0] hi_addr;
  logic              out_rdy;
  logic              out_vld_q;
  logic [OUT_W-1:0]  out_freq_q;
  logic [OUT_W-1:0]  out_freq_d;
  logic [FREQ_W-1:0] d_lo;
  logic [FREQ_W-1:0] d_hi;

  // Silence floor register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= SILENCE_FLOOR_RST;
    end else if (cfg_we_i) begin
      floor_q <= cfg_wdata_i;
    end
  end

  nnfq_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .floor_i (floor_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .freq_i  (in_freq_i),
    .valid_o (srch_vld),
    .ready_i (fetch_rdy),
    .item_o  (srch_item)
  );

  // Neighbouring notes; past either end both point at the end note.
  always_comb begin
    lo_addr = (srch_item.below == '0) ? '0 : ADDR_W'(srch_item.below - CNT_W'(1));
    hi_addr = (srch_item.below >= CNT_W'(NOTE_COUNT)) ? ADDR_W'(NOTE_COUNT - 1)
                                                      : ADDR_W'(srch_item.below);
  end

  assign out_rdy   = !out_vld_q || out_ready_i;
  assign fetch_rdy = !fetch_vld_q || out_rdy;

  // Fetch stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_vld_q <= 1'b0;
    end else if (fetch_rdy) begin
      fetch_vld_q <= srch_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch_rdy) begin
      fetch_x_q      <= srch_item.x;
      fetch_silent_q <= srch_item.silent;
      lo_v_q         <= NOTE_TABLE[lo_addr];
      hi_v_q         <= NOTE_TABLE[hi_addr];
    end
  end

  // Pick the nearer note; an exact tie goes to the upper one.
  always_comb begin
    d_lo = fetch_x_q - FREQ_W'(lo_v_q);
    d_hi = FREQ_W'(hi_v_q) - fetch_x_q;
    if (fetch_silent_q) begin
      out_freq_d = '0;
    end else if (d_lo < d_hi) begin
      out_freq_d = lo_v_q;
    end else begin
      out_freq_d = hi_v_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= fetch_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      out_freq_q <= out_freq_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_freq_o  = out_freq_q;

`ifndef SYNTH
  // The fetched neighbours are always in table order.
  a_nbr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_vld_q |-> lo_v_q <= hi_v_q)
    else $error("fetched neighbours out of order");

  // With the output register empty the whole pipeline can move.
  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ready_o)
    else $error("input stalled with an empty output register");

  // A silent item leaves as zero.
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_vld_q && fetch_silent_q && out_rdy |=> out_vld_q && (out_freq_q == '0))
    else $error("silent item gave a non-zero result");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the nearest note frequency quantiser.
module tb;

  localparam int FREQ_W      = nnfq_pkg::FREQ_W;
  localparam int OUT_W       = nnfq_pkg::OUT_W;
  localparam int NOTE_COUNT  = nnfq_pkg::NOTE_COUNT;
  localparam int FRAC_BITS   = nnfq_pkg::FRAC_BITS;
  localparam int LATENCY     = 10;
  localparam int STALL_LIMIT = 400;
  localparam logic [FREQ_W-1:0] FREQ_MAX   = {FREQ_W{1'b1}};
  localparam logic [FREQ_W-1:0] FLOOR_RST  = FREQ_W'(5120);
  localparam logic [63:0]       CLAMP_OUT  = 64'((1 << OUT_W) - 1);

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [FREQ_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [FREQ_W-1:0] in_freq_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [OUT_W-1:0]  out_freq_o;

  // Predictor state: the note table, the floor and the results still to come.
  logic [OUT_W-1:0]  note_hz [NOTE_COUNT];
  logic [FREQ_W-1:0] floor_now = FLOOR_RST;
  logic [OUT_W-1:0]  freq_expect [$];
  int                fail_count = 0;
  int                idle_cycles = 0;
  bit                steady = 1'b0;

  nearest_note_freq_quantizer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_freq_i  (in_freq_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_freq_o (out_freq_o)
  );

  // Clock with a period of 12 time units.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Semitone factors 2^(k/12) scaled by 10^11.
  function automatic logic [63:0] semitone_factor(int k);
    case (k)
      0:       return 64'd100000000000;
      1:       return 64'd105946309436;
      2:       return 64'd112246204831;
      3:       return 64'd118920711500;
      4:       return 64'd125992104989;
      5:       return 64'd133483985417;
      6:       return 64'd141421356237;
      7:       return 64'd149830707688;
      8:       return 64'd158740105197;
      9:       return 64'd168179283051;
      10:      return 64'd178179743628;
      default: return 64'd188774862536;
    endcase
  endfunction

  // Note frequency in Q14.8, note 69 at 440 Hz, rounded half up and saturated.
  function automatic logic [OUT_W-1:0] tempered_note(int idx);
    int          steps;
    int          octave;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    steps  = idx + 3;
    octave = steps / 12 - 6;
    num    = (64'd440 * semitone_factor(steps % 12)) << FRAC_BITS;
    den    = 64'd100000000000;
    if (octave > 0) begin
      num = num << octave;
    end else if (octave < 0) begin
      den = den << (-octave);
    end
    q = (num + den / 2) / den;
    if (q > CLAMP_OUT) begin
      q = CLAMP_OUT;
    end
    return q[OUT_W-1:0];
  endfunction

  // Expected result for one sample: silence, a clamp at either end, or the nearer
  // neighbour with a tie going upwards.
  function automatic logic [OUT_W-1:0] nearest_note(logic [FREQ_W-1:0] x,
                                                    logic [FREQ_W-1:0] floor_v);
    int          above;
    logic [31:0] lo_v;
    logic [31:0] hi_v;
    if (x < floor_v) begin
      return '0;
    end
    above = 0;
    while (above < NOTE_COUNT && 32'(note_hz[above]) <= 32'(x)) begin
      above++;
    end
    if (above == 0) begin
      return note_hz[0];
    end
    if (above >= NOTE_COUNT) begin
      return note_hz[NOTE_COUNT-1];
    end
    lo_v = 32'(note_hz[above-1]);
    hi_v = 32'(note_hz[above]);
    if ((32'(x) - lo_v) < (hi_v - 32'(x))) begin
      return lo_v[OUT_W-1:0];
    end
    return hi_v[OUT_W-1:0];
  endfunction

  // Random sample: mostly near notes, midpoints and the floor, some across the range.
  function automatic logic [FREQ_W-1:0] pick_freq();
    int          kind;
    int          i;
    int          v;
    logic [31:0] mid;
    kind = $urandom_range(0, 9);
    i    = $urandom_range(0, NOTE_COUNT - 2);
    mid  = (32'(note_hz[i]) + 32'(note_hz[i+1]) + 32'($urandom_range(0, 1))) / 2;
    case (kind)
      0, 1, 2, 3: v = int'(note_hz[$urandom_range(0, NOTE_COUNT - 1)]) +
                      $urandom_range(0, 8) - 4;
      4:          v = int'(mid);
      5:          v = int'(mid) + $urandom_range(0, 2) - 1;
      6, 7:       v = int'($urandom & 32'(FREQ_MAX));
      8:          v = $urandom_range(0, int'(note_hz[NOTE_COUNT-1]) + 4000);
      default:    v = int'(floor_now) + $urandom_range(0, 4) - 2;
    endcase
    if (v < 0) begin
      v = 0;
    end
    if (v > int'(FREQ_MAX)) begin
      v = int'(FREQ_MAX);
    end
    return v[FREQ_W-1:0];
  endfunction

  // Reports a wrong or unexpected result; only the first ten are printed.
  task automatic flag_mismatch(logic [OUT_W-1:0] want, logic [OUT_W-1:0] got, bit orphan);
    fail_count++;
    if (fail_count <= 10) begin
      if (orphan) begin
        $display("mismatch: result %0d arrived with no item outstanding", got);
      end else begin
        $display("mismatch: out_freq expected %0d, got %0d", want, got);
      end
    end
  endtask

  // Records each accepted item's prediction and checks each accepted result item.
  always @(posedge clk_i) begin : scoreboard
    logic [OUT_W-1:0] want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        freq_expect.push_back(nearest_note(in_freq_i, floor_now));
      end
      if (out_valid_o && out_ready_i) begin
        if (freq_expect.size() == 0) begin
          flag_mismatch('0, out_freq_o, 1'b1);
        end else begin
          want = freq_expect.pop_front();
          if (out_freq_o !== want) begin
            flag_mismatch(want, out_freq_o, 1'b0);
          end
        end
      end
    end
  end

  // Ends the run when no item moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: a random stall before each item, none in steady stretches.
  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Sends one item after a random gap and returns once it has been accepted.
  task automatic send_item(logic [FREQ_W-1:0] x);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_freq_i  <= x;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // Holds the input back until every outstanding result item has come out.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (freq_expect.size() != 0);
  endtask

  // Writes the silence floor with the pipeline empty.
  task automatic write_floor(logic [FREQ_W-1:0] value);
    settle();
    repeat (LATENCY + 2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    floor_now    = value;
  endtask

  // Reset floor: silence around 20 Hz and the ends of the input range.
  task automatic test_reset_floor();
    send_item('0);
    send_item(FREQ_W'(FLOOR_RST - 1));
    send_item(FLOOR_RST);
    send_item(FREQ_W'(FLOOR_RST + 1));
    send_item(FREQ_W'(note_hz[0]));
    send_item(FREQ_MAX);
  endtask

  // Zero floor: clamps at both ends, an exact note and midpoints between notes.
  task automatic test_zero_floor();
    int          i;
    logic [31:0] sum;
    write_floor('0);
    send_item('0);
    send_item(FREQ_W'(32'(note_hz[0]) - 32'd1));
    send_item(FREQ_W'(note_hz[0]));
    send_item(FREQ_W'(note_hz[69]));
    send_item(FREQ_W'(note_hz[NOTE_COUNT-1]));
    send_item(FREQ_W'(32'(note_hz[NOTE_COUNT-1]) + 32'd1));
    send_item(FREQ_MAX);
    // An exact tie needs a neighbouring pair with an even sum.
    i = 0;
    while (i < NOTE_COUNT - 2 && ((32'(note_hz[i]) + 32'(note_hz[i+1])) % 2) != 0) begin
      i++;
    end
    sum = 32'(note_hz[i]) + 32'(note_hz[i+1]);
    send_item(FREQ_W'(sum / 2));
    send_item(FREQ_W'(sum / 2 - 1));
    send_item(FREQ_W'(sum / 2 + 1));
    // A pair with an odd sum has no tie; probe both sides of its middle.
    sum = 32'(note_hz[60]) + 32'(note_hz[61]);
    send_item(FREQ_W'(sum / 2));
    send_item(FREQ_W'((sum + 1) / 2));
  endtask

  // Highest floor: everything is silent except the largest sample.
  task automatic test_full_floor();
    write_floor(FREQ_MAX);
    send_item(FREQ_W'(FREQ_MAX - 1));
    send_item(FREQ_MAX);
  endtask

  // A phase of random items under one floor, in chunks that may run without idling.
  task automatic test_random_items(logic [FREQ_W-1:0] floor_v, int count, bit hold_mid);
    write_floor(floor_v);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if (hold_mid && n == count / 2) begin
        settle();
      end
      send_item(pick_freq());
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NOTE_COUNT; i++) begin
      note_hz[i] = tempered_note(i);
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_floor();
    test_zero_floor();
    test_full_floor();
    test_random_items(FLOOR_RST, 350, 1'b1);
    test_random_items(FREQ_W'($urandom_range(0, int'(note_hz[NOTE_COUNT-1]))), 350, 1'b0);
    test_random_items('0, 350, 1'b1);
    test_random_items(FREQ_W'(note_hz[$urandom_range(0, NOTE_COUNT - 1)]), 300, 1'b0);
    test_random_items(FREQ_W'($urandom & 32'(FREQ_MAX)), 150, 1'b0);
    test_random_items(FREQ_MAX, 100, 1'b0);

    settle();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0 && freq_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/nnfq_pkg.sv
rtl/core/nnfq_search.sv
rtl/core/nearest_note_freq_quantizer.sv
sim/tb.sv
